@@ hw/rtl/plid_pkg.sv @@
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and codes for the positional list with insert and delete.
// ----------------------------------------------------------------------------
package plid_pkg;

  localparam int DATA_W  = 32;
  localparam int POS_W   = 7;
  localparam int CNT_W   = 7;
  localparam int FUNC_W  = 2;
  localparam int STAT_W  = 2;
  localparam int TDATA_W = 48;

  localparam logic [FUNC_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [FUNC_W-1:0] OP_DELETE   = 2'd1;
  localparam logic [FUNC_W-1:0] OP_TRAVERSE = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd3;

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [DATA_W-1:0] element;
    logic [CNT_W-1:0]         count;
    logic                     last;
  } result_t;

endpackage

@@ hw/rtl/positional_list_insert_delete.sv @@
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of signed words with insert and delete by position, and a full traverse.
// ----------------------------------------------------------------------------
// Channel   Dir  Beat fields (low bit first)
// s_axis    in   func[1:0], position[8:2], value[40:9]
// m_axis    out  status[1:0], element[33:2], count[40:34]; tlast = last
//
// One address counter walks the list RAM. An insert reads each entry from the
// top down to the position and writes it one place higher, a delete writes each
// entry above the position one place lower, and a traverse reads and captures
// each entry before its beat goes out. Every result beat waits while the output
// is stalled. Errors skip the RAM and go straight to the result beat.
// Reset clears the state and the count, not the RAM; no entry beyond the count is used.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
  parameter int DEPTH = 64
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [plid_pkg::TDATA_W-1:0]  s_axis_tdata,  // func, position, value
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [plid_pkg::TDATA_W-1:0]  m_axis_tdata,  // status, element, count
  output logic                          m_axis_tlast
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int CMPW = ((CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W) + 1;

  typedef enum logic [10:0] {
    S_IDLE    = 11'b00000000001,
    S_INS_RD  = 11'b00000000010,
    S_INS_WR  = 11'b00000000100,
    S_INS_PUT = 11'b00000001000,
    S_DEL_RD0 = 11'b00000010000,
    S_DEL_CAP = 11'b00000100000,
    S_DEL_RD  = 11'b00001000000,
    S_DEL_WR  = 11'b00010000000,
    S_TRV_RD  = 11'b00100000000,
    S_TRV_CAP = 11'b01000000000,
    S_EMIT    = 11'b10000000000
  } state_t;

  state_t state, state_next;

  logic [CW-1:0] cnt, cnt_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] tgt, tgt_next;
  logic signed [plid_pkg::DATA_W-1:0] val, val_next;
  plid_pkg::result_t res, res_next;

  logic [plid_pkg::DATA_W-1:0] mem [DEPTH];
  logic [plid_pkg::DATA_W-1:0] rdata;
  logic                        we;
  logic [CW-1:0]               waddr;
  logic [CW-1:0]               raddr;
  logic [plid_pkg::DATA_W-1:0] wdata;

  logic [plid_pkg::FUNC_W-1:0]        in_func;
  logic [plid_pkg::POS_W-1:0]         in_pos;
  logic signed [plid_pkg::DATA_W-1:0] in_val;
  logic [CMPW-1:0]                    pos_c;
  logic [CMPW-1:0]                    cnt_c;
  logic [CW-1:0]                      idx_inc;
  logic [CW-1:0]                      idx_dec;
  logic                               accept;
  logic                               out_space;
  logic                               out_push;

  assign in_func = s_axis_tdata[1:0];
  assign in_pos  = s_axis_tdata[8:2];
  assign in_val  = s_axis_tdata[40:9];
  assign pos_c   = CMPW'(in_pos);
  assign cnt_c   = CMPW'(cnt);
  assign idx_inc = idx + CW'(1);
  assign idx_dec = idx - CW'(1);

  assign s_axis_tready = (state == S_IDLE) && !rst;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_push      = (state == S_EMIT) && out_space;

  always_comb begin
    case (state)
      S_INS_RD: raddr = idx_dec;
      S_DEL_RD: raddr = idx_inc;
      default:  raddr = idx;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    rdata <= mem[raddr[AW-1:0]];
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    idx_next   = idx;
    tgt_next   = tgt;
    val_next   = val;
    res_next   = res;
    we         = 1'b0;
    waddr      = idx;
    wdata      = rdata;

    case (state)
      S_IDLE: begin
        if (accept) begin
          res_next.status  = plid_pkg::ST_BADPOS;
          res_next.element = '0;
          res_next.count   = plid_pkg::CNT_W'(cnt);
          res_next.last    = 1'b1;
          val_next         = in_val;
          state_next       = S_EMIT;
          case (in_func)
            plid_pkg::OP_INSERT: begin
              if (cnt_c == CMPW'(DEPTH)) begin
                res_next.status = plid_pkg::ST_FULL;
              end else if (pos_c != '0 && pos_c <= cnt_c + CMPW'(1)) begin
                idx_next = cnt;
                tgt_next = CW'(pos_c - CMPW'(1));
                state_next = (cnt == CW'(pos_c - CMPW'(1))) ? S_INS_PUT : S_INS_RD;
              end
            end
            plid_pkg::OP_DELETE: begin
              if (cnt == '0) begin
                res_next.status = plid_pkg::ST_EMPTY;
              end else if (pos_c != '0 && pos_c <= cnt_c) begin
                idx_next   = CW'(pos_c - CMPW'(1));
                state_next = S_DEL_RD0;
              end
            end
            plid_pkg::OP_TRAVERSE: begin
              if (cnt == '0) begin
                res_next.status = plid_pkg::ST_EMPTY;
              end else begin
                idx_next   = '0;
                state_next = S_TRV_RD;
              end
            end
            default: begin
              res_next.status = plid_pkg::ST_BADPOS;
            end
          endcase
        end
      end
      S_INS_RD: begin
        state_next = S_INS_WR;
      end
      S_INS_WR: begin
        // Move one entry up; the read of the one below was issued last cycle.
        we         = 1'b1;
        waddr      = idx;
        wdata      = rdata;
        idx_next   = idx_dec;
        state_next = (idx_dec == tgt) ? S_INS_PUT : S_INS_RD;
      end
      S_INS_PUT: begin
        we               = 1'b1;
        waddr            = tgt;
        wdata            = val;
        cnt_next         = cnt + CW'(1);
        res_next.status  = plid_pkg::ST_OK;
        res_next.element = val;
        res_next.count   = plid_pkg::CNT_W'(cnt + CW'(1));
        res_next.last    = 1'b1;
        state_next       = S_EMIT;
      end
      S_DEL_RD0: begin
        state_next = S_DEL_CAP;
      end
      S_DEL_CAP: begin
        res_next.element = rdata;
        if (idx_inc == cnt) begin
          cnt_next        = cnt - CW'(1);
          res_next.status = plid_pkg::ST_OK;
          res_next.count  = plid_pkg::CNT_W'(cnt - CW'(1));
          res_next.last   = 1'b1;
          state_next      = S_EMIT;
        end else begin
          state_next = S_DEL_RD;
        end
      end
      S_DEL_RD: begin
        state_next = S_DEL_WR;
      end
      S_DEL_WR: begin
        we       = 1'b1;
        waddr    = idx;
        wdata    = rdata;
        idx_next = idx_inc;
        if (CW'(idx + CW'(2)) == cnt) begin
          cnt_next        = cnt - CW'(1);
          res_next.status = plid_pkg::ST_OK;
          res_next.count  = plid_pkg::CNT_W'(cnt - CW'(1));
          res_next.last   = 1'b1;
          state_next      = S_EMIT;
        end else begin
          state_next = S_DEL_RD;
        end
      end
      S_TRV_RD: begin
        state_next = S_TRV_CAP;
      end
      S_TRV_CAP: begin
        res_next.status  = plid_pkg::ST_OK;
        res_next.element = rdata;
        res_next.count   = plid_pkg::CNT_W'(cnt);
        res_next.last    = (idx_inc == cnt);
        idx_next         = idx_inc;
        state_next       = S_EMIT;
      end
      S_EMIT: begin
        // A traverse keeps walking until the beat marked last is handed to the output register.
        if (out_space) begin
          state_next = res.last ? S_IDLE : S_TRV_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    tgt <= tgt_next;
    val <= val_next;
    res <= res_next;
  end

  plid_out_reg u_out (
    .clk           (clk),
    .rst           (rst),
    .push          (out_push),
    .res           (res),
    .space         (out_space),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

@@ hw/rtl/plid_out_reg.sv @@
// ----------------------------------------------------------------------------
// plid_out_reg
// One-entry result register between the sequencer and the output stream.
// ----------------------------------------------------------------------------
module plid_out_reg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  input  plid_pkg::result_t             res,
  output logic                          space,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [plid_pkg::TDATA_W-1:0]  m_axis_tdata,  // status, element, count
  output logic                          m_axis_tlast
);

  plid_pkg::result_t held;
  logic              full;

  // The slot frees in the same cycle its beat is taken.
  assign space = !full || m_axis_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (push) begin
      full <= 1'b1;
    end else if (m_axis_tready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      held <= res;
    end
  end

  assign m_axis_tvalid = full;
  assign m_axis_tdata  = {7'd0, held.count, held.element, held.status};
  assign m_axis_tlast  = held.last;

endmodule

@@ test/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the positional list. Insert, delete, traverse and
// the unused operation code are driven over the input stream, and every
// output beat is checked against a behavioral copy of the list kept here.
// ----------------------------------------------------------------------------
module testbench;

  localparam int LIST_DEPTH     = 64;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES   = 200;
  localparam int TIMEOUT_CYCLES = 1500000;

  localparam logic [plid_pkg::FUNC_W-1:0] OP_UNUSED = 2'd3;

  // Behavioral copy of the list; builds the expected result beats.
  class list_scoreboard;
    logic signed [plid_pkg::DATA_W-1:0] entries[LIST_DEPTH];
    int      n_entries;
    int      peak_entries;
    plid_pkg::result_t expected_q[$];
    int      n_errors;
    int      n_results;
    int      op_total[4];

    function void expect_beat(logic [plid_pkg::STAT_W-1:0] status,
                              logic signed [plid_pkg::DATA_W-1:0] element,
                              logic last);
      plid_pkg::result_t r;
      r.status  = status;
      r.element = element;
      r.count   = n_entries[plid_pkg::CNT_W-1:0];
      r.last    = last;
      expected_q.push_back(r);
    endfunction

    function void note_input(logic [plid_pkg::FUNC_W-1:0] func,
                             logic [plid_pkg::POS_W-1:0] pos,
                             logic signed [plid_pkg::DATA_W-1:0] value);
      int p;
      logic signed [plid_pkg::DATA_W-1:0] removed;
      p = int'(pos);
      op_total[func]++;
      case (func)
        plid_pkg::OP_INSERT: begin
          // The full check takes precedence over the position check.
          if (n_entries >= LIST_DEPTH) begin
            expect_beat(plid_pkg::ST_FULL, '0, 1'b1);
          end else if (p < 1 || p > n_entries + 1) begin
            expect_beat(plid_pkg::ST_BADPOS, '0, 1'b1);
          end else begin
            for (int i = n_entries; i > p - 1; i--) entries[i] = entries[i-1];
            entries[p-1] = value;
            n_entries++;
            expect_beat(plid_pkg::ST_OK, value, 1'b1);
          end
        end
        plid_pkg::OP_DELETE: begin
          if (n_entries == 0) begin
            expect_beat(plid_pkg::ST_EMPTY, '0, 1'b1);
          end else if (p < 1 || p > n_entries) begin
            expect_beat(plid_pkg::ST_BADPOS, '0, 1'b1);
          end else begin
            removed = entries[p-1];
            for (int i = p - 1; i + 1 < n_entries; i++) entries[i] = entries[i+1];
            n_entries--;
            expect_beat(plid_pkg::ST_OK, removed, 1'b1);
          end
        end
        plid_pkg::OP_TRAVERSE: begin
          if (n_entries == 0) begin
            expect_beat(plid_pkg::ST_EMPTY, '0, 1'b1);
          end else begin
            for (int i = 0; i < n_entries; i++)
              expect_beat(plid_pkg::ST_OK, entries[i], i == n_entries - 1);
          end
        end
        default: begin
          expect_beat(plid_pkg::ST_BADPOS, '0, 1'b1);
        end
      endcase
      if (n_entries > peak_entries) peak_entries = n_entries;
    endfunction

    function void check_result(plid_pkg::result_t got);
      plid_pkg::result_t want;
      n_results++;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got status %0d element %0d",
                 $time, got.status, got.element);
        $display("%0t: unexpected beat: count %0d last %0b", $time, got.count, got.last);
        n_errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.status !== want.status) begin
        $display("%0t: status mismatch: expected %0d, got %0d", $time, want.status, got.status);
        n_errors++;
      end
      if (got.element !== want.element) begin
        $display("%0t: element mismatch: expected %0d, got %0d", $time, want.element,
                 got.element);
        n_errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t: count mismatch: expected %0d, got %0d", $time, want.count, got.count);
        n_errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last mismatch: expected %0b, got %0b", $time, want.last, got.last);
        n_errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                         clk;
  logic                         rst           = 1'b1;
  logic                         s_axis_tvalid = 1'b0;
  logic                         s_axis_tready;
  logic [plid_pkg::TDATA_W-1:0] s_axis_tdata  = '0;  // func, position, value
  logic                         m_axis_tvalid;
  logic                         m_axis_tready = 1'b0;
  logic [plid_pkg::TDATA_W-1:0] m_axis_tdata;        // status, element, count
  logic                         m_axis_tlast;

  list_scoreboard list_sb;
  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_left     = 0;
  logic hold_request = 1'b0;
  int items_sent    = 0;

  positional_list_insert_delete #(
    .DEPTH(LIST_DEPTH)
  ) DUT (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Output side: random backpressure, or a long hold-off when requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_request) begin
      hold_request = 1'b0;
      hold_left <= RX_HOLD_CYCLES;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      list_sb.check_result({m_axis_tdata[1:0], m_axis_tdata[33:2], m_axis_tdata[40:34],
                            m_axis_tlast});
  end

  task automatic send_item(input logic [plid_pkg::FUNC_W-1:0] func, input int pos,
                           input logic [plid_pkg::DATA_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'b0, value, pos[plid_pkg::POS_W-1:0], func};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    list_sb.note_input(func, pos[plid_pkg::POS_W-1:0], value);
    items_sent++;
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (list_sb.pending() != 0);
  endtask

  // Mostly plain random words, with the extremes mixed in now and then.
  function automatic logic [plid_pkg::DATA_W-1:0] pick_value();
    case ($urandom_range(15))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      2:       return 32'h0000_0000;
      3:       return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic random_ops(input int n, input int ins_w, input int del_w);
    int r;
    int cnt;
    for (int k = 0; k < n; k++) begin
      r   = $urandom_range(99);
      cnt = list_sb.n_entries;
      if (r < ins_w)
        send_item(plid_pkg::OP_INSERT, $urandom_range(cnt + 1, 1), pick_value());
      else if (r < ins_w + del_w)
        send_item(plid_pkg::OP_DELETE, $urandom_range((cnt > 0) ? cnt : 1, 1), pick_value());
      else if (r < ins_w + del_w + 8)
        send_item(plid_pkg::OP_TRAVERSE, $urandom_range(127), $urandom);
      else if (r < ins_w + del_w + 12)
        send_item(OP_UNUSED, $urandom_range(127), $urandom);
      else
        send_item(plid_pkg::FUNC_W'($urandom_range(3)), $urandom_range(127), pick_value());
    end
  endtask

  // Grow the list to capacity, poke the full and boundary cases, then empty it.
  task automatic fill_and_drain();
    while (list_sb.n_entries < LIST_DEPTH)
      send_item(plid_pkg::OP_INSERT, $urandom_range(list_sb.n_entries + 1, 1), pick_value());
    send_item(plid_pkg::OP_INSERT, 1, $urandom);
    send_item(plid_pkg::OP_INSERT, 127, $urandom);
    send_item(plid_pkg::OP_DELETE, 0, $urandom);
    send_item(plid_pkg::OP_DELETE, LIST_DEPTH + 1, $urandom);
    send_item(plid_pkg::OP_TRAVERSE, 0, 0);
    send_item(plid_pkg::OP_DELETE, LIST_DEPTH, $urandom);
    send_item(plid_pkg::OP_INSERT, LIST_DEPTH, pick_value());
    while (list_sb.n_entries > 0)
      send_item(plid_pkg::OP_DELETE, $urandom_range(list_sb.n_entries, 1), $urandom);
    send_item(plid_pkg::OP_DELETE, 1, 0);
    send_item(plid_pkg::OP_TRAVERSE, 0, 0);
  endtask

  initial begin
    list_sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty list, bad positions, extremes, both ends and the middle.
    send_item(plid_pkg::OP_TRAVERSE, 0, 0);
    send_item(plid_pkg::OP_DELETE, 1, 0);
    send_item(plid_pkg::OP_DELETE, 0, 0);
    send_item(plid_pkg::OP_INSERT, 0, 32'h0000_0005);
    send_item(plid_pkg::OP_INSERT, 2, 32'h0000_0005);
    send_item(plid_pkg::OP_INSERT, 1, 32'h7FFF_FFFF);
    send_item(plid_pkg::OP_INSERT, 1, 32'h8000_0000);
    send_item(plid_pkg::OP_INSERT, 3, 32'hFFFF_FFFF);
    send_item(plid_pkg::OP_INSERT, 2, 32'h0000_0000);
    send_item(plid_pkg::OP_INSERT, 127, 32'h1234_5678);
    send_item(OP_UNUSED, 127, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 0, 32'h0000_0000);
    send_item(plid_pkg::OP_TRAVERSE, 127, 32'hFFFF_FFFF);
    send_item(plid_pkg::OP_DELETE, 0, 0);
    send_item(plid_pkg::OP_DELETE, 5, 0);
    send_item(plid_pkg::OP_DELETE, 4, 0);
    send_item(plid_pkg::OP_DELETE, 1, 0);
    send_item(plid_pkg::OP_DELETE, 2, 0);
    send_item(plid_pkg::OP_TRAVERSE, 0, 0);
    send_item(plid_pkg::OP_DELETE, 1, 0);
    send_item(plid_pkg::OP_TRAVERSE, 0, 0);

    random_ops(60, 55, 25);

    // Hold the output off while the input keeps offering beats.
    hold_request = 1'b1;
    send_item(plid_pkg::OP_TRAVERSE, 0, 0);
    random_ops(8, 40, 20);
    wait_drained();

    tx_idle_pct  = 56;
    rx_stall_pct = 0;
    random_ops(80, 40, 35);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 56;
    fill_and_drain();
    wait_drained();

    tx_idle_pct  = 11;
    rx_stall_pct = 11;
    random_ops(100, 45, 35);
    wait_drained();

    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    random_ops(40, 40, 35);
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d input beats and %0d result beats; longest list was %0d entries.",
             items_sent, list_sb.n_results, list_sb.peak_entries);
    $display("Operations: %0d inserts, %0d deletes, %0d traverses, %0d unused codes.",
             list_sb.op_total[plid_pkg::OP_INSERT], list_sb.op_total[plid_pkg::OP_DELETE],
             list_sb.op_total[plid_pkg::OP_TRAVERSE], list_sb.op_total[OP_UNUSED]);
    if (list_sb.n_errors == 0 && list_sb.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * 20);
    $display("Timeout with %0d result beats still expected.", list_sb.pending());
    $display("Test completed with failures");
    $finish;
  end

endmodule
